// ----- design/fbp_pkg.sv -----
// Shared types, constants and helpers for the fixed block pool free list.
// No dependencies; imported by the controller, the datapath and the top level.
package fbp_pkg;

  localparam int MaxBlocks = 256;
  localparam int IdxW      = $clog2(MaxBlocks);      // block index width
  localparam int PtrW      = $clog2(MaxBlocks + 1);  // ring pointer / count width
  localparam int TotW      = 32;
  localparam int StW       = 3;

  // result status codes
  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StEmpty    = 3'd1;
  localparam logic [StW-1:0] StNotAlloc = 3'd2;
  localparam logic [StW-1:0] StRange    = 3'd3;
  localparam logic [StW-1:0] StFull     = 3'd4;

  // request op codes
  localparam logic OpAlloc  = 1'b0;
  localparam logic OpReturn = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture request, ring and in-use reads issued
    logic exec;  // apply request and load result register
  } fbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_busy;  // in-use bits are being cleared
  } fbp_sts_t;

  // ring advance, ring has count+1 entries
  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] pos,
                                                input logic [PtrW-1:0] count);
    logic [PtrW:0] p;
    p = {1'b0, pos} + 1'b1;
    if (p >= ({1'b0, count} + 1'b1)) begin
      p = '0;
    end
    return p[PtrW-1:0];
  endfunction

endpackage

// ----- design/fixed_block_pool_free_list.sv -----
// Top level of the fixed block pool free list: stream ports, config port.
// Depends on fbp_pkg, fbp_ctrl and fbp_dp.
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  s_axis   | in        | block_index[7:0]                         | op
//  m_axis   | out       | status, granted_index, alloc/ret totals  | -
//  cfg      | in        | block_count[8:0], write on cfg_we_i      | -
//
// Each request passes two steps: it is registered while the ring memory is
// read at the head pointer and the in-use bit at the request index, then it is
// applied and the result register is loaded.
// The next request is taken while the result waits; a request ready to
// execute waits only while the previous result is still held.
// Reset and a block_count write start a clearing pass over the in-use bits of
// blocks 0..count-1 (256 after reset), one per cycle, with s_axis_tready low;
// the ring itself needs no pass, a fill mark tracks which entries were rewritten.
module fixed_block_pool_free_list
  import fbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: tdata = block_index[7:0]; tuser = op[0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  // result: tdata = status[2:0], granted_index[10:3],
  //   allocations_total[42:11], returns_total[74:43], zero [79:75]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,
  // block count register
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  fbp_cmd_t        cmd;
  fbp_sts_t        sts;
  logic [StW-1:0]  status;
  logic [IdxW-1:0] granted;
  logic [TotW-1:0] alloc_tot, ret_tot;

  fbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbp_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .op_i               (s_axis_tuser[0]),
    .block_index_i      (s_axis_tdata),
    .status_o           (status),
    .granted_index_o    (granted),
    .allocations_total_o(alloc_tot),
    .returns_total_o    (ret_tot)
  );

  assign m_axis_tdata = {5'b0, ret_tot, alloc_tot, granted, status};

endmodule

// ----- design/fbp_ctrl.sv -----
// Request sequencer for the block pool: accept, execute, result handoff.
// Depends on fbp_pkg.
module fbp_ctrl
  import fbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  fbp_sts_t sts_i,
  output fbp_cmd_t cmd_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && !sts_i.init_busy;
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == SExec) && slot_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        if (cmd_o.load) begin
          state_d = SExec;
        end
      end
      SExec: begin
        if (cmd_o.exec) begin
          state_d     = SIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/fbp_dp.sv -----
// Datapath for the block pool: free ring memory, pointers, in-use bits, totals.
// Depends on fbp_pkg; sequenced by fbp_ctrl.
module fbp_dp
  import fbp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fbp_cmd_t        cmd_i,
  output fbp_sts_t        sts_o,
  input  logic            cfg_we_i,
  input  logic [PtrW-1:0] cfg_wdata_i,
  input  logic            op_i,
  input  logic [IdxW-1:0] block_index_i,
  output logic [StW-1:0]  status_o,
  output logic [IdxW-1:0] granted_index_o,
  output logic [TotW-1:0] allocations_total_o,
  output logic [TotW-1:0] returns_total_o
);

  logic [IdxW-1:0] ring_mem [MaxBlocks+1];
  logic            in_use_mem [MaxBlocks];

  logic [PtrW-1:0] count_q, head_q, tail_q, wmark_q;
  logic [PtrW-1:0] count_d, head_d, tail_d, wmark_d;
  logic [TotW-1:0] alloc_q, alloc_d, ret_q, ret_d;
  logic            clr_q, clr_d;
  logic [IdxW-1:0] clr_ptr_q, clr_ptr_d;
  logic            op_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] rd_q;
  logic            rd_init_q;
  logic            iu_rd_q;
  logic [StW-1:0]  status_q, status_d;
  logic [IdxW-1:0] granted_q, granted_d;
  logic            wr_en;
  logic            iu_we;
  logic [IdxW-1:0] iu_addr;
  logic            iu_wdata;
  logic [PtrW-1:0] cfg_n;
  logic [IdxW-1:0] head_blk;
  logic [PtrW-1:0] head_nx, tail_nx;

  // clamp written count to 1..MaxBlocks
  always_comb begin
    cfg_n = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cfg_n = PtrW'(1);
    end else if ({1'b0, cfg_wdata_i} > (PtrW+1)'(MaxBlocks)) begin
      cfg_n = PtrW'(MaxBlocks);
    end
  end

  // entries from the fill mark up to count-1 still hold their initial value;
  // the spare slot at count is always written before head reaches it
  assign head_blk = rd_init_q ? head_q[IdxW-1:0] : rd_q;
  assign head_nx  = ring_next(head_q, count_q);
  assign tail_nx  = ring_next(tail_q, count_q);

  assign sts_o.init_busy = clr_q;

  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    wmark_d   = wmark_q;
    alloc_d   = alloc_q;
    ret_d     = ret_q;
    clr_d     = clr_q;
    clr_ptr_d = clr_ptr_q;
    status_d  = status_q;
    granted_d = granted_q;
    wr_en     = 1'b0;
    iu_we     = 1'b0;
    iu_addr   = clr_ptr_q;
    iu_wdata  = 1'b0;
    if (cfg_we_i) begin
      count_d   = cfg_n;
      head_d    = '0;
      tail_d    = cfg_n;
      wmark_d   = '0;
      alloc_d   = '0;
      ret_d     = '0;
      clr_d     = 1'b1;
      clr_ptr_d = '0;
    end else if (clr_q) begin
      // one in-use bit cleared per cycle, blocks 0..count-1
      iu_we     = 1'b1;
      clr_ptr_d = clr_ptr_q + 1'b1;
      if ({1'b0, clr_ptr_q} == count_q - 1'b1) begin
        clr_d = 1'b0;
      end
    end else if (cmd_i.exec) begin
      status_d  = StOk;
      granted_d = '0;
      if (op_q == OpAlloc) begin
        if (head_q == tail_q || head_q > count_q) begin
          status_d = StEmpty;
        end else begin
          head_d    = head_nx;
          iu_we     = 1'b1;
          iu_addr   = head_blk;
          iu_wdata  = 1'b1;
          alloc_d   = alloc_q + 1'b1;
          granted_d = head_blk;
        end
      end else begin
        if ({1'b0, idx_q} >= count_q) begin
          status_d = StRange;
        end else if (!iu_rd_q) begin
          status_d = StNotAlloc;
        end else if (tail_nx == head_q || tail_q > count_q) begin
          status_d = StFull;
        end else begin
          wr_en    = 1'b1;
          tail_d   = tail_nx;
          iu_we    = 1'b1;
          iu_addr  = idx_q;
          iu_wdata = 1'b0;
          ret_d    = ret_q + 1'b1;
          if (tail_q == wmark_q && tail_q < count_q) begin
            wmark_d = wmark_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= PtrW'(MaxBlocks);
      head_q    <= '0;
      tail_q    <= PtrW'(MaxBlocks);
      wmark_q   <= '0;
      alloc_q   <= '0;
      ret_q     <= '0;
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
    end else begin
      count_q   <= count_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      wmark_q   <= wmark_d;
      alloc_q   <= alloc_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      clr_ptr_q <= clr_ptr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      idx_q <= block_index_i;
    end
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // free ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[tail_q] <= idx_q;
    end
    rd_q      <= ring_mem[head_q];
    rd_init_q <= (head_q >= wmark_q) && (head_q < count_q);
  end

  // in-use bits, one write port and one read at the request's index
  always_ff @(posedge clk_i) begin
    if (iu_we) begin
      in_use_mem[iu_addr] <= iu_wdata;
    end
    if (cmd_i.load) begin
      iu_rd_q <= in_use_mem[block_index_i];
    end
  end

  assign status_o            = status_q;
  assign granted_index_o     = granted_q;
  assign allocations_total_o = alloc_q;
  assign returns_total_o     = ret_q;

endmodule

// ----- design/fbp_checker.sv -----
// Port-level checker for fixed_block_pool_free_list, bound to the top level.
// Depends on fbp_pkg for status codes.
module fbp_checker
  import fbp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one executes");

  // granted index only on a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != StOk |-> m_axis_tdata[10:3] == 8'd0)
    else $error("granted index on refused request");

  // status code in range, pad bits zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= StFull && m_axis_tdata[79:75] == 5'd0)
    else $error("bad status code or pad bits");

endmodule

bind fixed_block_pool_free_list fbp_checker u_fbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- verif/testbench.sv -----
// Self-checking bench for fixed_block_pool_free_list: directed table, then random phases.
// Carries its own model of the free ring. Needs fbp_pkg and the block's RTL, nothing more.
module testbench
  import fbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;  // long receiver hold-off
  localparam int unsigned NumPhases  = 6;

  // one result as it leaves the block
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  granted;
    logic [31:0] allocs;
    logic [31:0] rets;
  } pool_result_t;

  // one row of the directed script: a block_count write or a request
  typedef struct {
    bit           is_cfg;
    logic [8:0]   cfg_val;
    logic         op;
    logic [7:0]   idx;
    bit           typed;  // answer written in by hand
    pool_result_t ans;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // block_index[7:0]
  logic [0:0]  s_axis_tuser;   // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // status[2:0], granted[10:3], allocs[42:11], rets[74:43]
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;

  fixed_block_pool_free_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Model of the pool: ring of free indices one entry larger than the pool,
  // head/tail pointers, per-block in-use bits and the two wrapping totals.
  // ---------------------------------------------------------------------------
  logic [7:0]   ring_mem [0:MaxBlocks];
  bit           in_use   [MaxBlocks];
  int unsigned  head_pos;
  int unsigned  tail_pos;
  int unsigned  pool_size;
  logic [31:0]  alloc_tot;
  logic [31:0]  ret_tot;

  pool_result_t pending_answers [$];  // answers still owed by the block
  script_row_t  script_rows [$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_asks;
  int unsigned  hold_done;

  // block_count write: clamp to 1..MaxBlocks, refill ring in order, forget owners
  function automatic void pool_reload(logic [8:0] value);
    int unsigned n;
    n = 32'(value);
    if (n < 1) n = 1;
    if (n > MaxBlocks) n = MaxBlocks;
    pool_size = n;
    for (int i = 0; i <= MaxBlocks; i++) ring_mem[i] = (i < n) ? i[7:0] : 8'd0;
    for (int i = 0; i < MaxBlocks; i++) in_use[i] = 1'b0;
    head_pos  = 0;
    tail_pos  = n;
    alloc_tot = '0;
    ret_tot   = '0;
  endfunction

  // ring has pool_size+1 slots
  function automatic int unsigned step_slot(int unsigned pos);
    return (pos + 1 >= pool_size + 1) ? 0 : pos + 1;
  endfunction

  // answer of the pool to one request, with its effect on the state
  function automatic pool_result_t pool_serve(logic op, logic [7:0] idx);
    pool_result_t ans;
    int unsigned  blk;
    int unsigned  nxt;
    ans.status  = StOk;
    ans.granted = '0;
    if (op == OpAlloc) begin
      if (head_pos == tail_pos || head_pos > pool_size) begin
        ans.status = StEmpty;
      end else begin
        blk         = 32'(ring_mem[head_pos]);
        head_pos    = step_slot(head_pos);
        in_use[blk] = 1'b1;
        alloc_tot   = alloc_tot + 1;
        ans.granted = blk[7:0];
      end
    end else begin
      if (idx >= pool_size) begin
        ans.status = StRange;
      end else if (!in_use[idx]) begin
        ans.status = StNotAlloc;
      end else begin
        nxt = step_slot(tail_pos);
        if (nxt == head_pos || tail_pos > pool_size) begin
          ans.status = StFull;  // only if the in-use bits went inconsistent
        end else begin
          ring_mem[tail_pos] = idx;
          tail_pos           = nxt;
          in_use[idx]        = 1'b0;
          ret_tot            = ret_tot + 1;
        end
      end
    end
    ans.allocs = alloc_tot;
    ans.rets   = ret_tot;
    return ans;
  endfunction

  // a block currently held, searched from a random start; -1 if none
  function automatic int pick_held();
    int unsigned start;
    int unsigned k;
    start = $urandom_range(0, pool_size - 1);
    for (int i = 0; i < pool_size; i++) begin
      k = (start + i) % pool_size;
      if (in_use[k]) return k;
    end
    return -1;
  endfunction

  function automatic void cfg_row(logic [8:0] v);
    script_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    script_rows.push_back(r);
  endfunction

  function automatic void req_row(logic op, logic [7:0] idx);
    script_row_t r;
    r     = '{default: '0};
    r.op  = op;
    r.idx = idx;
    script_rows.push_back(r);
  endfunction

  function automatic void chk_row(logic op, logic [7:0] idx, logic [2:0] st,
                                  logic [7:0] gr, logic [31:0] at, logic [31:0] rt);
    script_row_t r;
    r       = '{default: '0};
    r.op    = op;
    r.idx   = idx;
    r.typed = 1'b1;
    r.ans   = '{status: st, granted: gr, allocs: at, rets: rt};
    script_rows.push_back(r);
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus a long hold-off on request from
  // the stimulus so the block fills up and drops s_axis_tready.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_done++;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // every accepted result against the oldest owed answer, field by field
  always @(posedge clk_i) begin : check_results
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        note_mismatch("result with no request pending", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          note_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
        if (m_axis_tdata[10:3] !== want.granted)
          note_mismatch("granted_index", 64'(m_axis_tdata[10:3]), 64'(want.granted));
        if (m_axis_tdata[42:11] !== want.allocs)
          note_mismatch("allocations_total", 64'(m_axis_tdata[42:11]), 64'(want.allocs));
        if (m_axis_tdata[74:43] !== want.rets)
          note_mismatch("returns_total", 64'(m_axis_tdata[74:43]), 64'(want.rets));
        if (m_axis_tdata[79:75] !== 5'd0)
          note_mismatch("tdata padding", 64'(m_axis_tdata[79:75]), 64'd0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, with a random gap first; returns at the accepting edge
  // with tvalid still high. The owed answer is the model's unless one is typed.
  task automatic offer_request(logic op, logic [7:0] idx, bit typed, pool_result_t typed_ans);
    pool_result_t ans;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ans = pool_serve(op, idx);
    pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  // stop offering and wait until every owed answer has come back
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // block_count write, only with the block idle
  task automatic write_block_count(logic [8:0] v);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    pool_reload(v);
    cfg_we_i    <= 1'b0;
  endtask

  // Random request: mostly allocates and returns of held blocks, some returns
  // of arbitrary indices (which may be out of range, held or never allocated).
  task automatic draw_request(int unsigned alloc_pct, output logic op, output logic [7:0] idx);
    int unsigned r;
    int          held;
    r   = $urandom_range(0, 99);
    op  = OpReturn;
    idx = 8'($urandom_range(0, 255));
    if (r < alloc_pct) begin
      op = OpAlloc;  // idx stays random, the block ignores it
    end else if (r < 92) begin
      held = pick_held();
      if (held < 0) op = OpAlloc;
      else idx = held[7:0];
    end
  endtask

  initial begin : stimulus
    int unsigned  phase_cfg [NumPhases];
    int unsigned  phase_len [NumPhases];
    int unsigned  alloc_pct;
    logic         op;
    logic [7:0]   idx;
    pool_result_t no_ans;

    phase_cfg = '{3, 256, 1, 40, 511, 0};
    phase_len = '{60, 400, 40, 120, 130, 100};
    no_ans    = '0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    send_idle_pct = 21;
    recv_idle_pct = 88;
    pool_reload(9'd256);

    // Directed script. From reset the pool has 256 blocks.
    chk_row(OpAlloc,  8'd0,   StOk,       8'd0, 32'd1, 32'd0);
    req_row(OpAlloc,  8'd0);
    req_row(OpReturn, 8'd1);
    chk_row(OpReturn, 8'd1,   StNotAlloc, 8'd0, 32'd2, 32'd1);  // double return
    chk_row(OpReturn, 8'd255, StNotAlloc, 8'd0, 32'd2, 32'd1);  // top index, never out
    req_row(OpAlloc,  8'd255);
    cfg_row(9'd0);                                              // zero taken as one block
    chk_row(OpReturn, 8'd1,   StRange,    8'd0, 32'd0, 32'd0);  // index == count
    chk_row(OpReturn, 8'd255, StRange,    8'd0, 32'd0, 32'd0);
    chk_row(OpReturn, 8'd0,   StNotAlloc, 8'd0, 32'd0, 32'd0);
    chk_row(OpAlloc,  8'd0,   StOk,       8'd0, 32'd1, 32'd0);
    chk_row(OpAlloc,  8'd0,   StEmpty,    8'd0, 32'd1, 32'd0);  // head meets tail
    req_row(OpReturn, 8'd0);
    req_row(OpAlloc,  8'd0);
    cfg_row(9'd2);
    req_row(OpAlloc,  8'd0);
    req_row(OpAlloc,  8'd0);
    req_row(OpAlloc,  8'd0);
    req_row(OpReturn, 8'd1);
    req_row(OpReturn, 8'd0);                                    // ring slot 0 rewritten after the tail wrap
    req_row(OpAlloc,  8'd0);
    chk_row(OpReturn, 8'd2,   StRange,    8'd0, 32'd3, 32'd2);
    cfg_row(9'd511);                                            // clamped to MaxBlocks
    chk_row(OpReturn, 8'd255, StNotAlloc, 8'd0, 32'd0, 32'd0);
    chk_row(OpAlloc,  8'd0,   StOk,       8'd0, 32'd1, 32'd0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[i]) begin
      if (script_rows[i].is_cfg) begin
        write_block_count(script_rows[i].cfg_val);
      end else begin
        offer_request(script_rows[i].op, script_rows[i].idx,
                      script_rows[i].typed, script_rows[i].ans);
      end
    end

    // Random phases, each after a fresh block_count. Idling: sender light and
    // receiver heavy, then swapped, then none at all.
    phase_cfg[NumPhases-1] = $urandom_range(2, 255);
    for (int p = 0; p < NumPhases; p++) begin
      write_block_count(9'(phase_cfg[p]));
      if (p < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 88;
      end else if (p < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int unsigned k = 0; k < phase_len[p]; k++) begin
        // fill the pool in the first three quarters, drain it in the rest
        alloc_pct = (k < phase_len[p] * 3 / 4) ? 85 : 20;
        if (p == 4 && k == 10) hold_asks++;   // receiver stalls, sender keeps pushing
        if (p == 5 && k == 50) quiesce();     // sender waits for every answer
        draw_request(alloc_pct, op, idx);
        offer_request(op, idx, 1'b0, no_ans);
      end
    end

    quiesce();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
